@@ rtl/hcbp_pkg.sv @@
package hcbp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int WORD_BITS    = 32;

    localparam int SYM_W   = $clog2(SYMBOL_COUNT);
    localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
    localparam int FREE_W  = $clog2(WORD_BITS + 1);
    localparam int NIBBLE_W = 4;

    // Widths of the request fields as they travel on the ports.
    localparam int IN_SYMBOL_W = 8;
    localparam int IN_CODE_W   = 32;
    localparam int IN_LEN_W    = 6;
    localparam int IN_BYTE_W   = 8;
    localparam int SYM_CMP_W   = IN_BYTE_W + 1;
    localparam int S_TDATA_W   = 56;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic
    {
        FUNC_LOAD   = 1'b0,
        FUNC_ENCODE = 1'b1
    } func_t;

    typedef enum logic
    {
        STATUS_OK       = 1'b0,
        STATUS_NO_ENTRY = 1'b1
    } status_t;

    // One symbol lookup handed from the table stage to the packer.
    typedef struct packed
    {
        logic [LEN_W-1:0]        len;
        logic [MAX_CODE_LEN-1:0] code;
        logic                    miss;
        logic                    op_end;
    } op_t;

    typedef struct packed
    {
        logic [WORD_BITS-1:0] word;
        logic                 final_word;
        status_t              status;
    } res_t;

endpackage

@@ rtl/hcbp_table.sv @@
module hcbp_table
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [hcbp_pkg::SYM_W-1:0]             wr_addr,
    input  logic [hcbp_pkg::MAX_CODE_LEN-1:0]      wr_code,
    input  logic [hcbp_pkg::LEN_W-1:0]             wr_len,
    input  logic                                   rd_en,
    input  logic [hcbp_pkg::SYM_W-1:0]             rd_addr,
    output logic [hcbp_pkg::MAX_CODE_LEN-1:0]      rd_code,
    output logic [hcbp_pkg::LEN_W-1:0]             rd_len
);

    logic [hcbp_pkg::MAX_CODE_LEN-1:0] code_mem [hcbp_pkg::SYMBOL_COUNT];
    logic [hcbp_pkg::LEN_W-1:0]        len_mem  [hcbp_pkg::SYMBOL_COUNT];
    logic [hcbp_pkg::SYMBOL_COUNT-1:0] valid_reg;
    logic [hcbp_pkg::SYMBOL_COUNT-1:0] valid_next;
    logic [hcbp_pkg::MAX_CODE_LEN-1:0] rd_code_reg;
    logic [hcbp_pkg::LEN_W-1:0]        rd_len_reg;
    logic                              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_mem[wr_addr] <= wr_code;
            len_mem[wr_addr]  <= wr_len;
        end
        if (rd_en)
        begin
            rd_code_reg <= code_mem[rd_addr];
            rd_len_reg  <= len_mem[rd_addr];
        end
    end

    // An entry never loaded since reset reads as having no code.
    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_code = rd_code_reg;
    assign rd_len  = rd_valid_reg ? rd_len_reg : '0;

endmodule

@@ rtl/hcbp_packer.sv @@
module hcbp_packer
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            op_valid,
    input  hcbp_pkg::op_t   op,
    output logic            op_ready,
    output logic            res_valid,
    output hcbp_pkg::res_t  res,
    input  logic            res_full
);

    logic [hcbp_pkg::WORD_BITS-1:0] acc_reg;
    logic [hcbp_pkg::WORD_BITS-1:0] acc_next;
    logic [hcbp_pkg::FREE_W-1:0]    free_reg;
    logic [hcbp_pkg::FREE_W-1:0]    free_next;
    logic                           aborted_reg;
    logic                           aborted_next;
    logic                           flush_reg;
    logic                           flush_next;

    logic                           take;
    logic [hcbp_pkg::FREE_W-1:0]    len_f;
    logic [hcbp_pkg::WORD_BITS-1:0] code_w;
    logic                           fits;
    logic [hcbp_pkg::FREE_W-1:0]    rem;
    logic [hcbp_pkg::WORD_BITS-1:0] acc_fill;
    logic [hcbp_pkg::FREE_W-1:0]    free_fill;

    assign op_ready  = !flush_reg && !res_full;
    assign take      = op_valid && op_ready;
    assign len_f     = hcbp_pkg::FREE_W'(op.len);
    assign code_w    = hcbp_pkg::WORD_BITS'(op.code);
    assign fits      = len_f <= free_reg;
    assign rem       = len_f - free_reg;
    assign acc_fill  = acc_reg | (code_w << (free_reg - len_f));
    assign free_fill = free_reg - len_f;

    always_comb
    begin
        acc_next     = acc_reg;
        free_next    = free_reg;
        aborted_next = aborted_reg;
        flush_next   = flush_reg;
        res_valid    = 1'b0;
        res          = '{word: '0, final_word: 1'b0, status: hcbp_pkg::STATUS_OK};
        priority if (flush_reg)
        begin
            // Bits left over from a code that crossed into a new word on the last byte.
            if (!res_full)
            begin
                res_valid      = 1'b1;
                res.word       = acc_reg;
                res.final_word = 1'b1;
                acc_next       = '0;
                free_next      = hcbp_pkg::FREE_W'(hcbp_pkg::WORD_BITS);
                flush_next     = 1'b0;
            end
        end
        else if (take && aborted_reg)
        begin
            if (op.op_end)
            begin
                aborted_next = 1'b0;
            end
        end
        else if (take && op.miss)
        begin
            res_valid      = 1'b1;
            res.final_word = 1'b1;
            res.status     = hcbp_pkg::STATUS_NO_ENTRY;
            acc_next       = '0;
            free_next      = hcbp_pkg::FREE_W'(hcbp_pkg::WORD_BITS);
            aborted_next   = !op.op_end;
        end
        else if (take && fits)
        begin
            if (free_fill == '0 || op.op_end)
            begin
                res_valid      = 1'b1;
                res.word       = acc_fill;
                res.final_word = op.op_end;
                acc_next       = '0;
                free_next      = hcbp_pkg::FREE_W'(hcbp_pkg::WORD_BITS);
            end
            else
            begin
                acc_next  = acc_fill;
                free_next = free_fill;
            end
        end
        else if (take)
        begin
            res_valid  = 1'b1;
            res.word   = acc_reg | (code_w >> rem);
            acc_next   = code_w << (hcbp_pkg::FREE_W'(hcbp_pkg::WORD_BITS) - rem);
            free_next  = hcbp_pkg::FREE_W'(hcbp_pkg::WORD_BITS) - rem;
            flush_next = op.op_end;
        end
        else
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            free_reg    <= hcbp_pkg::FREE_W'(hcbp_pkg::WORD_BITS);
            aborted_reg <= 1'b0;
            flush_reg   <= 1'b0;
        end
        else
        begin
            acc_reg     <= acc_next;
            free_reg    <= free_next;
            aborted_reg <= aborted_next;
            flush_reg   <= flush_next;
        end
    end

endmodule

@@ rtl/hcbp_out_fifo.sv @@
module hcbp_out_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  hcbp_pkg::res_t  wr_data,
    output logic            full,
    output logic            rd_valid,
    input  logic            rd_ready,
    output hcbp_pkg::res_t  rd_data
);

    hcbp_pkg::res_t                 mem [hcbp_pkg::FIFO_DEPTH];
    logic [hcbp_pkg::FIFO_AW-1:0]   wptr_reg;
    logic [hcbp_pkg::FIFO_AW-1:0]   rptr_reg;
    logic [hcbp_pkg::FIFO_AW:0]     count_reg;
    logic [hcbp_pkg::FIFO_AW:0]     count_next;
    logic                           push;
    logic                           pop;

    assign full     = count_reg == (hcbp_pkg::FIFO_AW + 1)'(hcbp_pkg::FIFO_DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_en && !full;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

endmodule

@@ rtl/huffman_code_bit_packer.sv @@
// A data byte's first word is registered by the table read and again by the result queue.
// Throughput: one byte per cycle in byte mode while the packer and result queue accept; in
// nibble mode each nibble takes its own table read, so a new byte waits for the high nibble's
// read; a last byte whose code spills into a new word holds the packer to emit the rest.
// Reset clears the table valid flags, the accumulator (32 free bits), the abort flag, the mode
// and the result queue at once; the table needs no clearing pass.
module huffman_code_bit_packer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,       // nibble_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // symbol[7:0], code_bits[39:8], code_len[45:40], data_byte[53:46], zero[55:54]
    input  logic [55:0] s_axis_tdata,
    input  logic        s_axis_tlast,    // end_of_data
    input  logic        s_axis_tuser,    // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // packed_word[31:0]
    output logic        m_axis_tlast,    // final_word
    output logic        m_axis_tuser     // status
);

    logic [hcbp_pkg::IN_SYMBOL_W-1:0] in_symbol;
    logic [hcbp_pkg::IN_CODE_W-1:0]   in_code;
    logic [hcbp_pkg::IN_LEN_W-1:0]    in_len;
    logic [hcbp_pkg::IN_BYTE_W-1:0]   in_byte;

    logic                             nibble_mode_reg;
    logic                             hi_pending_reg;
    logic                             hi_pending_next;
    logic [hcbp_pkg::NIBBLE_W-1:0]    hi_nibble_reg;
    logic                             hi_end_reg;
    logic                             b_valid_reg;
    logic                             b_valid_next;
    logic                             b_end_reg;
    logic                             b_end_next;
    logic                             b_oor_reg;
    logic                             b_oor_next;

    logic                             in_acc;
    logic                             is_enc;
    logic                             is_load;
    logic                             issue_hi;
    logic                             rd_en;
    logic                             b_adv;
    logic [hcbp_pkg::SYM_W-1:0]       rd_addr;

    logic                             wr_en;
    logic [hcbp_pkg::LEN_W-1:0]       wr_len;
    logic [hcbp_pkg::WORD_BITS:0]     wr_mask;
    logic [hcbp_pkg::MAX_CODE_LEN-1:0] wr_code;

    logic [hcbp_pkg::MAX_CODE_LEN-1:0] rd_code;
    logic [hcbp_pkg::LEN_W-1:0]        rd_len;

    hcbp_pkg::op_t                    op;
    logic                             op_ready;
    logic                             res_valid;
    hcbp_pkg::res_t                   res;
    logic                             res_full;
    hcbp_pkg::res_t                   out_res;

    assign in_symbol = s_axis_tdata[7:0];
    assign in_code   = s_axis_tdata[39:8];
    assign in_len    = s_axis_tdata[45:40];
    assign in_byte   = s_axis_tdata[53:46];

    assign b_adv         = !b_valid_reg || op_ready;
    assign s_axis_tready = b_adv && !hi_pending_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_enc        = in_acc && (hcbp_pkg::func_t'(s_axis_tuser) == hcbp_pkg::FUNC_ENCODE);
    assign is_load       = in_acc && (hcbp_pkg::func_t'(s_axis_tuser) == hcbp_pkg::FUNC_LOAD);
    assign issue_hi      = hi_pending_reg && b_adv;
    assign rd_en         = is_enc || issue_hi;

    // Table writes: out-of-range entries are dropped, long lengths clamp, stray bits are masked.
    assign wr_en   = is_load && (hcbp_pkg::SYM_CMP_W'(in_symbol)
                                 < hcbp_pkg::SYM_CMP_W'(hcbp_pkg::SYMBOL_COUNT));
    assign wr_len  = (in_len > hcbp_pkg::IN_LEN_W'(hcbp_pkg::MAX_CODE_LEN))
                     ? hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN)
                     : hcbp_pkg::LEN_W'(in_len);
    assign wr_mask = ((hcbp_pkg::WORD_BITS + 1)'(1) << wr_len) - (hcbp_pkg::WORD_BITS + 1)'(1);
    assign wr_code = in_code[hcbp_pkg::MAX_CODE_LEN-1:0] & wr_mask[hcbp_pkg::MAX_CODE_LEN-1:0];

    always_comb
    begin
        if (issue_hi)
        begin
            rd_addr    = hcbp_pkg::SYM_W'(hi_nibble_reg);
            b_oor_next = 1'b0;
            b_end_next = hi_end_reg;
        end
        else if (nibble_mode_reg)
        begin
            rd_addr    = hcbp_pkg::SYM_W'(in_byte[hcbp_pkg::NIBBLE_W-1:0]);
            b_oor_next = 1'b0;
            b_end_next = 1'b0;
        end
        else
        begin
            rd_addr    = in_byte[hcbp_pkg::SYM_W-1:0];
            b_oor_next = hcbp_pkg::SYM_CMP_W'(in_byte)
                         >= hcbp_pkg::SYM_CMP_W'(hcbp_pkg::SYMBOL_COUNT);
            b_end_next = s_axis_tlast;
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (rd_en)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_adv)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        hi_pending_next = hi_pending_reg;
        if (is_enc && nibble_mode_reg)
        begin
            hi_pending_next = 1'b1;
        end
        else if (issue_hi)
        begin
            hi_pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nibble_mode_reg <= 1'b0;
            hi_pending_reg  <= 1'b0;
            b_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                nibble_mode_reg <= cfg_wdata;
            end
            hi_pending_reg <= hi_pending_next;
            b_valid_reg    <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_enc)
        begin
            hi_nibble_reg <= in_byte[2*hcbp_pkg::NIBBLE_W-1:hcbp_pkg::NIBBLE_W];
            hi_end_reg    <= s_axis_tlast;
        end
        if (rd_en)
        begin
            b_end_reg <= b_end_next;
            b_oor_reg <= b_oor_next;
        end
    end

    hcbp_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (in_symbol[hcbp_pkg::SYM_W-1:0]),
        .wr_code (wr_code),
        .wr_len  (wr_len),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_code (rd_code),
        .rd_len  (rd_len)
    );

    assign op.len    = rd_len;
    assign op.code   = rd_code;
    assign op.miss   = b_oor_reg || (rd_len == '0);
    assign op.op_end = b_end_reg;

    hcbp_packer u_packer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (b_valid_reg),
        .op        (op),
        .op_ready  (op_ready),
        .res_valid (res_valid),
        .res       (res),
        .res_full  (res_full)
    );

    hcbp_out_fifo u_out_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_valid),
        .wr_data  (res),
        .full     (res_full),
        .rd_valid (m_axis_tvalid),
        .rd_ready (m_axis_tready),
        .rd_data  (out_res)
    );

    assign m_axis_tdata = out_res.word;
    assign m_axis_tlast = out_res.final_word;
    assign m_axis_tuser = out_res.status;

endmodule

@@ rtl/hcbp_checker.sv @@
module hcbp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic        cfg_wdata,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [55:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // Nothing is offered straight after reset.
    property p_idle_after_reset;
        @(posedge clk) !rst_n |=> !m_axis_tvalid;
    endproperty
    a_idle_after_reset: assert property (p_idle_after_reset)
        else $error("result offered right after reset");

    // An error result is an empty word that closes the stream.
    property p_error_shape;
        @(posedge clk) disable iff (!rst_n)
            (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == 32'd0));
    endproperty
    a_error_shape: assert property (p_error_shape)
        else $error("error result carries data or lacks the final mark");

    // A stalled result keeps its contents.
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
            (m_axis_tvalid && !m_axis_tready) |=>
                (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
                 && $stable(m_axis_tuser));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("stalled result changed");

endmodule

bind huffman_code_bit_packer hcbp_checker u_checker (.*);
